>>> rtl/uif_pkg.sv
// uif_pkg: shared types, constants and header byte function of the udp/ipv4 frame builder
// no dependencies; imported by the top level, front, queue and back modules
package uif_pkg;

  // frame limits
  localparam int MAX_FRAME_BYTES = 1600;
  localparam int HDR_BYTES       = 14 + 20 + 8;
  localparam int HDR_IDX_W       = $clog2(HDR_BYTES);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic CFG_LOCAL_MAC = 1'b0;
  localparam logic CFG_LOCAL_IP  = 1'b1;

  // input request codes
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // fixed header words
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] IP_VER_IHL    = 16'h4500;
  localparam logic [15:0] IP_ID         = 16'h0001;
  localparam logic [15:0] IP_TTL_PROTO  = 16'h4011;
  localparam logic [7:0]  BCAST_BYTE    = 8'hFF;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_REJ,
    CMD_BYTE
  } uif_cmd_kind_t;

  // one queued command: a full header, a reject or one payload byte
  typedef struct packed {
    uif_cmd_kind_t kind;
    logic [31:0]   sip;
    logic [31:0]   dip;
    logic [15:0]   sport;
    logic [15:0]   dport;
    logic [15:0]   tot_len;
    logic [15:0]   udp_len;
    logic [15:0]   csum;
    logic          empty;
    logic [7:0]    data;
    logic          last;
  } uif_cmd_t;

  // front to queue
  typedef struct packed {
    logic     push;
    uif_cmd_t cmd;
  } uif_push_t;

  // queue to back
  typedef struct packed {
    logic     valid;
    uif_cmd_t cmd;
  } uif_head_t;

  // header byte at position idx, network order
  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                          input uif_cmd_t c,
                                          input logic [47:0] mac);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: b = BCAST_BYTE;
      6'd6:  b = mac[47:40];
      6'd7:  b = mac[39:32];
      6'd8:  b = mac[31:24];
      6'd9:  b = mac[23:16];
      6'd10: b = mac[15:8];
      6'd11: b = mac[7:0];
      6'd12: b = ETH_TYPE_IPV4[15:8];
      6'd13: b = ETH_TYPE_IPV4[7:0];
      6'd14: b = IP_VER_IHL[15:8];
      6'd15: b = IP_VER_IHL[7:0];
      6'd16: b = c.tot_len[15:8];
      6'd17: b = c.tot_len[7:0];
      6'd18: b = IP_ID[15:8];
      6'd19: b = IP_ID[7:0];
      6'd22: b = IP_TTL_PROTO[15:8];
      6'd23: b = IP_TTL_PROTO[7:0];
      6'd24: b = c.csum[15:8];
      6'd25: b = c.csum[7:0];
      6'd26: b = c.sip[31:24];
      6'd27: b = c.sip[23:16];
      6'd28: b = c.sip[15:8];
      6'd29: b = c.sip[7:0];
      6'd30: b = c.dip[31:24];
      6'd31: b = c.dip[23:16];
      6'd32: b = c.dip[15:8];
      6'd33: b = c.dip[7:0];
      6'd34: b = c.sport[15:8];
      6'd35: b = c.sport[7:0];
      6'd36: b = c.dport[15:8];
      6'd37: b = c.dport[7:0];
      6'd38: b = c.udp_len[15:8];
      6'd39: b = c.udp_len[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/uif_if.sv
// uif_in_if / uif_out_if: valid/ready channels of the frame builder
// depends on nothing; used by the top level and its front and back parts
interface uif_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] dest_ip;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] payload_len;
  logic        broadcast;
  logic [7:0]  payload_byte;

  modport source (output valid, req_type, dest_ip, source_port, dest_port,
                  payload_len, broadcast, payload_byte, input ready);
  modport sink (input valid, req_type, dest_ip, source_port, dest_port,
                payload_len, broadcast, payload_byte, output ready);
endinterface

interface uif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last;
  logic       rejected;

  modport source (output valid, frame_byte, last, rejected, input ready);
  modport sink (input valid, frame_byte, last, rejected, output ready);
endinterface

>>> rtl/udp_ipv4_frame_builder_top.sv
// udp_ipv4_frame_builder_top: udp/ipv4/ethernet transmit frame builder
// depends on uif_pkg, uif_if, uif_front, uif_cmd_queue, uif_back
//
// usage:
//   in_ch carries start beats (req_type 0: addresses, ports, payload length,
//   broadcast) and payload beats (req_type 1: one byte). out_ch gives the
//   frame one byte a beat: 42 header bytes then the payload, last set on the
//   final byte, or a single rejected beat for an oversize frame. payload beats
//   outside an open frame are dropped; a start beat in a frame closes it.
//   the user must write local_mac, local_ip (cfg_we) only while idle; unenforced.
// throughput:
//   a payload byte passes through the command queue and the output register to
//   out_ch, one per cycle sustained while out_ch is ready and no header is
//   being sent. a start beat is one input beat and 42 header bytes from the
//   back end; the 4-entry command queue lets input continue meanwhile.
// reset:
//   synchronous, active low; clears frame tracking, queue and output valid;
//   both configuration registers return to zero.
// stall:
//   out_ch holds its beat while ready is low; when the queue fills, in_ch
//   ready drops until the back end drains an entry.
module udp_ipv4_frame_builder_top import uif_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  uif_in_if.sink      in_ch,
  uif_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0] local_mac_r;
  logic [31:0] local_ip_r;
  uif_push_t   push;
  uif_head_t   head;
  logic        pop;
  logic        q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r <= '0;
      local_ip_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_MAC: local_mac_r <= cfg_data;
        CFG_LOCAL_IP:  local_ip_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  uif_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .local_ip (local_ip_r),
    .push     (push)
  );

  uif_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  uif_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .local_mac (local_mac_r),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/uif_front.sv
// uif_front: accepts input beats, tracks the open frame, builds queue commands
// depends on uif_pkg and uif_in_if
module uif_front import uif_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  uif_in_if.sink      in_ch,
  input  logic        q_full,
  input  logic [31:0] local_ip,
  output uif_push_t   push
);

  logic        in_frame_r, in_frame_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        accept;
  logic [31:0] sip, dip;
  logic [15:0] tot_len;
  logic [19:0] sum_raw;
  logic [16:0] sum_f1;
  logic [15:0] sum_f2;
  logic        oversize;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // addresses and lengths of a start beat
  assign sip      = in_ch.broadcast ? 32'h0 : local_ip;
  assign dip      = in_ch.broadcast ? 32'hFFFF_FFFF : in_ch.dest_ip;
  assign tot_len  = in_ch.payload_len + 16'd28;
  assign oversize = ({1'b0, in_ch.payload_len} + 17'(HDR_BYTES)) > 17'(MAX_FRAME_BYTES);

  // ip header checksum, ones' complement with two folds
  assign sum_raw = 20'(IP_VER_IHL) + 20'(tot_len) + 20'(IP_ID) + 20'(IP_TTL_PROTO)
                 + 20'(sip[31:16]) + 20'(sip[15:0]) + 20'(dip[31:16]) + 20'(dip[15:0]);
  assign sum_f1  = {1'b0, sum_raw[15:0]} + {13'b0, sum_raw[19:16]};
  assign sum_f2  = sum_f1[15:0] + {15'b0, sum_f1[16]};

  // classify the beat and update frame tracking
  always_comb begin
    in_frame_nxt       = in_frame_r;
    bytes_left_nxt     = bytes_left_r;
    push.push          = 1'b0;
    push.cmd.kind      = CMD_BYTE;
    push.cmd.sip       = sip;
    push.cmd.dip       = dip;
    push.cmd.sport     = in_ch.source_port;
    push.cmd.dport     = in_ch.dest_port;
    push.cmd.tot_len   = tot_len;
    push.cmd.udp_len   = in_ch.payload_len + 16'd8;
    push.cmd.csum      = ~sum_f2;
    push.cmd.empty     = (in_ch.payload_len == 16'd0);
    push.cmd.data      = in_ch.payload_byte;
    push.cmd.last      = (bytes_left_r == 16'd1);
    if (accept) begin
      if (in_ch.req_type == REQ_START) begin
        in_frame_nxt   = 1'b0;
        bytes_left_nxt = 16'd0;
        push.push      = 1'b1;
        if (oversize) begin
          push.cmd.kind = CMD_REJ;
        end else begin
          push.cmd.kind = CMD_HDR;
          if (in_ch.payload_len != 16'd0) begin
            in_frame_nxt   = 1'b1;
            bytes_left_nxt = in_ch.payload_len;
          end
        end
      end else if (in_frame_r) begin
        push.push      = 1'b1;
        push.cmd.kind  = CMD_BYTE;
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) begin
          in_frame_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bytes_left_r <= 16'd0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

>>> rtl/uif_cmd_queue.sv
// uif_cmd_queue: short command fifo between front and back
// depends on uif_pkg
module uif_cmd_queue import uif_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  uif_push_t push,
  input  logic      pop,
  output uif_head_t head,
  output logic      full
);

  uif_cmd_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

>>> rtl/uif_back.sv
// uif_back: expands queued commands into frame bytes behind an output register
// depends on uif_pkg and uif_out_if
module uif_back import uif_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  uif_head_t   head,
  output logic        pop,
  input  logic [47:0] local_mac,
  uif_out_if.source   out_ch
);

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

  logic                 busy_r, busy_nxt;
  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  uif_cmd_t             cur_r, cur_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_rej_r, out_rej_nxt;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = slot_free && !busy_r && head.valid;

  // byte selection: header in progress first, else the queue head
  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_rej_nxt   = out_rej_r;
    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = hdr_byte(idx_r, cur_r, local_mac);
        out_last_nxt  = (idx_r == HDR_LAST) && cur_r.empty;
        out_rej_nxt   = 1'b0;
        idx_nxt       = idx_r + 1'b1;
        busy_nxt      = (idx_r != HDR_LAST);
      end else if (head.valid) begin
        out_valid_nxt = 1'b1;
        out_rej_nxt   = 1'b0;
        case (head.cmd.kind)
          CMD_HDR: begin
            out_byte_nxt = hdr_byte('0, head.cmd, local_mac);
            out_last_nxt = 1'b0;
            cur_nxt      = head.cmd;
            idx_nxt      = HDR_IDX_W'(1);
            busy_nxt     = 1'b1;
          end
          CMD_REJ: begin
            out_byte_nxt = 8'h00;
            out_last_nxt = 1'b0;
            out_rej_nxt  = 1'b1;
          end
          default: begin
            out_byte_nxt = head.cmd.data;
            out_last_nxt = head.cmd.last;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_rej_r  <= out_rej_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.rejected   = out_rej_r;

endmodule

>>> rtl/uif_checker.sv
// uif_checker: port-level assertions of the frame builder, bound to the top level
// depends on udp_ipv4_frame_builder_top
module uif_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_last,
  input logic       out_rejected
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_last) && $stable(out_rejected))
    else $error("output beat changed under stall");

  // a reject beat carries no byte and no last mark
  a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_frame_byte == 8'h00 && !out_last)
    else $error("reject beat with data or last");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the command queue, so input is ready next
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind udp_ipv4_frame_builder_top uif_checker u_uif_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_frame_byte (out_ch.frame_byte),
  .out_last       (out_ch.last),
  .out_rejected   (out_ch.rejected)
);
